// ----- rtl/tri_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// tri_pkg
// Shared types, codes and constants for the trapezoid-rule integrator.
// ----------------------------------------------------------------------------
package tri_pkg;

    localparam int FRAC_BITS = 16;
    localparam int IN_W      = 24;
    localparam int STEPS_W   = 16;
    localparam int OUT_W     = 48;
    localparam int FX_W      = 42;
    localparam int ANG_W     = 35;
    localparam int CX_W      = 34;
    localparam int H_BITS    = IN_W + 1 + FRAC_BITS;
    localparam int CNT_W     = $clog2(H_BITS);

    localparam logic [1:0] OP_NONE   = 2'd0;
    localparam logic [1:0] OP_SQUARE = 2'd1;
    localparam logic [1:0] OP_CUBE   = 2'd2;
    localparam logic [1:0] OP_SINE   = 2'd3;

    localparam logic [1:0] ST_OK     = 2'd0;
    localparam logic [1:0] ST_BAD_OP = 2'd1;
    localparam logic [1:0] ST_SAT    = 2'd2;

    // Angles are Q5.30.
    localparam logic signed [ANG_W-1:0] ANG_TWO_PI  = 35'sd6746518852;
    localparam logic signed [ANG_W-1:0] ANG_PI      = 35'sd3373259426;
    localparam logic signed [ANG_W-1:0] ANG_HALF_PI = 35'sd1686629713;
    localparam logic signed [CX_W-1:0]  CORDIC_GAIN = 34'sd652032874;

    typedef struct packed {
        logic [1:0]                op;
        logic signed [IN_W-1:0]    lower_bound;
        logic signed [IN_W-1:0]    upper_bound;
        logic [STEPS_W-1:0]        steps;
    } t_req;

    typedef struct packed {
        logic signed [OUT_W-1:0]   integral;
        logic [1:0]                status;
    } t_rsp;

    typedef struct packed {
        logic                      start;
        logic [1:0]                op;
        logic signed [IN_W-1:0]    x;
    } t_ev_req;

    typedef struct packed {
        logic                      done;
        logic signed [FX_W-1:0]    fx;
    } t_ev_rsp;

    typedef enum logic [3:0] {
        S_IDLE, S_DIV, S_SIGN, S_EVAL, S_WAIT, S_POINT, S_MPREP, S_MUL, S_RND, S_FIN
    } t_state;

    typedef enum logic [3:0] {
        E_IDLE, E_SQR, E_RSQ, E_CUB, E_RCU, E_RED, E_WRAP, E_FOLD, E_ROT, E_SRND, E_DONE
    } t_ev_state;

    function automatic logic signed [ANG_W-1:0] atan_q30(input logic [4:0] idx);
        logic signed [ANG_W-1:0] v;
        case (idx)
            5'd0:  v = 35'sd843314856;
            5'd1:  v = 35'sd497837829;
            5'd2:  v = 35'sd263043836;
            5'd3:  v = 35'sd133525158;
            5'd4:  v = 35'sd67021686;
            5'd5:  v = 35'sd33543515;
            5'd6:  v = 35'sd16775850;
            5'd7:  v = 35'sd8388437;
            5'd8:  v = 35'sd4194282;
            5'd9:  v = 35'sd2097149;
            5'd10: v = 35'sd1048575;
            5'd11: v = 35'sd524287;
            5'd12: v = 35'sd262143;
            5'd13: v = 35'sd131071;
            5'd14: v = 35'sd65535;
            5'd15: v = 35'sd32767;
            5'd16: v = 35'sd16383;
            5'd17: v = 35'sd8191;
            5'd18: v = 35'sd4095;
            5'd19: v = 35'sd2047;
            5'd20: v = 35'sd1023;
            5'd21: v = 35'sd511;
            5'd22: v = 35'sd255;
            5'd23: v = 35'sd127;
            5'd24: v = 35'sd63;
            5'd25: v = 35'sd31;
            5'd26: v = 35'sd15;
            5'd27: v = 35'sd7;
            5'd28: v = 35'sd3;
            5'd29: v = 35'sd1;
            default: v = '0;
        endcase
        return v;
    endfunction

endpackage
`default_nettype wire

// ----- rtl/tri_eval.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// tri_eval
// Integrand evaluator: one shared multiplier for the polynomials, range
// reduction and an iterative rotation-mode CORDIC for sine.
// ----------------------------------------------------------------------------
module tri_eval #(
    parameter int CORDIC_ITERATIONS = 18
) (
    input  wire                   i_clk,
    input  wire                   i_rst_n,
    input  wire tri_pkg::t_ev_req i_req,
    output tri_pkg::t_ev_rsp      o_rsp
);
    localparam int IT_W = (CORDIC_ITERATIONS > 2) ? $clog2(CORDIC_ITERATIONS) : 1;
    localparam int MAG_W = tri_pkg::IN_W + 30 - tri_pkg::FRAC_BITS;

    tri_pkg::t_ev_state r_state, n_state;

    logic [1:0]                         r_op;
    logic signed [tri_pkg::IN_W-1:0]    r_x;
    logic signed [55:0]                 r_prod;
    logic signed [31:0]                 r_sq;
    logic signed [tri_pkg::FX_W-1:0]    r_fx;
    logic [MAG_W-1:0]                   r_mag;
    logic                               r_neg;
    logic [2:0]                         r_k;
    logic signed [tri_pkg::ANG_W-1:0]   r_ang;
    logic signed [tri_pkg::CX_W-1:0]    r_cx, r_cy;
    logic [IT_W-1:0]                    r_it;

    logic signed [31:0]                 mul_a;
    logic signed [55:0]                 mul_p;
    logic signed [55:0]                 sq_sum;
    logic signed [56:0]                 cu_sum;
    logic [MAG_W+2:0]                   red_diff;
    logic signed [tri_pkg::ANG_W-1:0]   rem_s, wrap_t, wrap_a;
    logic signed [tri_pkg::CX_W-1:0]    dx, dy;
    logic signed [tri_pkg::ANG_W-1:0]   at;
    logic signed [tri_pkg::CX_W:0]      cy_rnd;
    logic                               ev_done;

    // The multiplier is shared by the square and the cube.
    assign mul_a  = (r_state == tri_pkg::E_CUB) ? r_sq : 32'(r_x);
    assign mul_p  = mul_a * r_x;
    assign sq_sum = r_prod + 56'sd32768;
    assign cu_sum = 57'(r_prod) + 57'sd16384;

    assign red_diff = {3'b000, r_mag} - ((MAG_W+3)'(tri_pkg::ANG_TWO_PI) << r_k);
    assign rem_s    = tri_pkg::ANG_W'({2'b00, r_mag[32:0]});
    assign wrap_t   = (r_neg && (r_mag != '0)) ? tri_pkg::ANG_TWO_PI - rem_s : rem_s;
    assign wrap_a   = (wrap_t > tri_pkg::ANG_PI) ? wrap_t - tri_pkg::ANG_TWO_PI : wrap_t;

    assign dx     = r_cy >>> r_it;
    assign dy     = r_cx >>> r_it;
    assign at     = tri_pkg::atan_q30(5'(r_it));
    assign cy_rnd = (tri_pkg::CX_W+1)'(r_cy) + (tri_pkg::CX_W+1)'(8192);

    always_comb begin
        n_state = r_state;
        case (r_state)
            tri_pkg::E_IDLE: begin
                if (i_req.start) begin
                    n_state = (i_req.op == tri_pkg::OP_SINE) ? tri_pkg::E_RED : tri_pkg::E_SQR;
                end
            end
            tri_pkg::E_SQR:  n_state = tri_pkg::E_RSQ;
            tri_pkg::E_RSQ:  n_state = (r_op == tri_pkg::OP_SQUARE) ? tri_pkg::E_DONE
                                                                    : tri_pkg::E_CUB;
            tri_pkg::E_CUB:  n_state = tri_pkg::E_RCU;
            tri_pkg::E_RCU:  n_state = tri_pkg::E_DONE;
            tri_pkg::E_RED:  n_state = (r_k == 3'd0) ? tri_pkg::E_WRAP : tri_pkg::E_RED;
            tri_pkg::E_WRAP: n_state = tri_pkg::E_FOLD;
            tri_pkg::E_FOLD: n_state = tri_pkg::E_ROT;
            tri_pkg::E_ROT: begin
                if (r_it == IT_W'(CORDIC_ITERATIONS - 1)) begin
                    n_state = tri_pkg::E_SRND;
                end
            end
            tri_pkg::E_SRND: n_state = tri_pkg::E_DONE;
            tri_pkg::E_DONE: n_state = tri_pkg::E_IDLE;
            default:         n_state = tri_pkg::E_IDLE;
        endcase
    end

    always_comb begin
        ev_done = (r_state == tri_pkg::E_DONE);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= tri_pkg::E_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        case (r_state)
            tri_pkg::E_IDLE: begin
                r_op  <= i_req.op;
                r_x   <= i_req.x;
                r_neg <= i_req.x[tri_pkg::IN_W-1];
                r_mag <= {(i_req.x[tri_pkg::IN_W-1] ? -i_req.x : i_req.x),
                          (30 - tri_pkg::FRAC_BITS)'(0)};
                r_k   <= 3'd5;
            end
            tri_pkg::E_SQR: r_prod <= mul_p;
            tri_pkg::E_RSQ: begin
                r_sq <= sq_sum[47:16];
                r_fx <= tri_pkg::FX_W'(sq_sum[47:16]);
            end
            tri_pkg::E_CUB: r_prod <= mul_p;
            tri_pkg::E_RCU: r_fx <= cu_sum[56:15];
            tri_pkg::E_RED: begin
                if (!red_diff[MAG_W+2]) begin
                    r_mag <= red_diff[MAG_W-1:0];
                end
                r_k <= r_k - 3'd1;
            end
            tri_pkg::E_WRAP: r_ang <= wrap_a;
            tri_pkg::E_FOLD: begin
                // Fold into the right half plane using sin(pi - x) = sin(x).
                if (r_ang > tri_pkg::ANG_HALF_PI) begin
                    r_ang <= tri_pkg::ANG_PI - r_ang;
                end else if (r_ang < -tri_pkg::ANG_HALF_PI) begin
                    r_ang <= -tri_pkg::ANG_PI - r_ang;
                end
                r_cx <= tri_pkg::CORDIC_GAIN;
                r_cy <= '0;
                r_it <= '0;
            end
            tri_pkg::E_ROT: begin
                if (!r_ang[tri_pkg::ANG_W-1]) begin
                    r_cx  <= r_cx - dx;
                    r_cy  <= r_cy + dy;
                    r_ang <= r_ang - at;
                end else begin
                    r_cx  <= r_cx + dx;
                    r_cy  <= r_cy - dy;
                    r_ang <= r_ang + at;
                end
                r_it <= r_it + 1'b1;
            end
            tri_pkg::E_SRND: r_fx <= tri_pkg::FX_W'($signed(cy_rnd[tri_pkg::CX_W:14]));
            default: ;
        endcase
    end

    assign o_rsp.done = ev_done;
    assign o_rsp.fx   = r_fx;

endmodule
`default_nettype wire

// ----- rtl/trapezoid_rule_integrator.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// trapezoid_rule_integrator
// Composite trapezoidal rule over x squared, two x cubed or sine, Q8.16 in,
// Q32.16 out, with saturation and status.
// ----------------------------------------------------------------------------
//  channel   ports                 handshake
//  request   start, busy, i_req    beat taken when start is high and busy low
//  result    o_done, o_rsp         one-cycle strobe, cannot be held off
//
//  An invalid select or zero steps answers in the next cycle.
//  Otherwise: a serial divide for h, then (n + 1) integrand evaluations for
//  x squared, two x cubed or sine, then a serial multiply, a rounding step
//  and a saturation step. The evaluator and the one-bit divide/multiply
//  loops set the rate. Reset clears the sequencers and the done flag only;
//  busy stays high for the whole of a valid request.
// ----------------------------------------------------------------------------
module trapezoid_rule_integrator #(
    parameter int CORDIC_ITERATIONS = 18
) (
    input  wire                i_clk,
    input  wire                i_rst_n,
    input  wire                start,
    input  wire tri_pkg::t_req i_req,
    output logic               busy,
    output logic               o_done,
    output tri_pkg::t_rsp      o_rsp
);
    localparam int H_BITS = tri_pkg::H_BITS;
    localparam int CNT_W  = tri_pkg::CNT_W;
    localparam int IN_W   = tri_pkg::IN_W;
    localparam int FX_W   = tri_pkg::FX_W;
    localparam int ACC_W  = H_BITS + tri_pkg::STEPS_W + 1;

    localparam logic [1:0] PH_A   = 2'd0;
    localparam logic [1:0] PH_B   = 2'd1;
    localparam logic [1:0] PH_MID = 2'd2;

    tri_pkg::t_state r_state, n_state;

    logic [1:0]                  r_op;
    logic signed [IN_W-1:0]      r_a, r_b;
    logic [15:0]                 r_n, r_idx;
    logic                        r_dneg;
    logic [H_BITS-1:0]           r_num, r_quo;
    logic [15:0]                 r_rem;
    logic [CNT_W-1:0]            r_cnt;
    logic signed [H_BITS:0]      r_h;
    logic signed [ACC_W-1:0]     r_acc;
    logic signed [IN_W-1:0]      r_x;
    logic signed [63:0]          r_sum;
    logic                        r_sat;
    logic [1:0]                  r_phase;
    logic [63:0]                 r_smag;
    logic                        r_neg;
    logic [63:0]                 r_phi;
    logic [72:0]                 r_q;
    logic                        r_done;
    tri_pkg::t_rsp               r_rsp;

    logic                        accept;
    logic signed [IN_W:0]        diff;
    logic [16:0]                 rem_sh, rem_sub;
    logic signed [H_BITS:0]      pt_sum;
    logic signed [FX_W:0]        addend;
    logic signed [64:0]          sum_w;
    logic [64:0]                 mul_t;
    logic [105:0]                rnd;
    logic [72:0]                 lim;
    logic [72:0]                 q_sat;
    tri_pkg::t_ev_req            ev_req;
    tri_pkg::t_ev_rsp            ev_rsp;

    assign accept  = start && !busy;
    assign diff    = (IN_W+1)'(i_req.upper_bound) - (IN_W+1)'(i_req.lower_bound);

    assign rem_sh  = {r_rem, r_num[H_BITS-1]};
    assign rem_sub = rem_sh - {1'b0, r_n};

    assign pt_sum  = (H_BITS+1)'(r_a) + $signed(r_acc[ACC_W-1:tri_pkg::FRAC_BITS]);

    // Interior samples carry weight two.
    assign addend  = (r_phase == PH_MID) ? {ev_rsp.fx, 1'b0} : (FX_W+1)'(ev_rsp.fx);
    assign sum_w   = 65'(r_sum) + 65'(addend);

    assign mul_t   = {1'b0, r_phi} + (r_quo[0] ? {1'b0, r_smag} : 65'd0);
    assign rnd     = {1'b0, r_phi, r_quo} + (106'd1 << (2 * tri_pkg::FRAC_BITS));
    assign lim     = r_neg ? (73'd1 << (tri_pkg::OUT_W - 1))
                           : ((73'd1 << (tri_pkg::OUT_W - 1)) - 73'd1);
    assign q_sat   = (r_q > lim) ? lim : r_q;

    tri_eval #(
        .CORDIC_ITERATIONS(CORDIC_ITERATIONS)
    ) u_eval (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_req  (ev_req),
        .o_rsp  (ev_rsp)
    );

    always_comb begin
        n_state = r_state;
        case (r_state)
            tri_pkg::S_IDLE: begin
                if (accept && (i_req.op != tri_pkg::OP_NONE) && (i_req.steps != '0)) begin
                    n_state = tri_pkg::S_DIV;
                end
            end
            tri_pkg::S_DIV:   n_state = (r_cnt == '0) ? tri_pkg::S_SIGN : tri_pkg::S_DIV;
            tri_pkg::S_SIGN:  n_state = tri_pkg::S_EVAL;
            tri_pkg::S_EVAL:  n_state = tri_pkg::S_WAIT;
            tri_pkg::S_WAIT: begin
                if (ev_rsp.done) begin
                    if (r_phase == PH_A) begin
                        n_state = tri_pkg::S_EVAL;
                    end else if (r_phase == PH_B) begin
                        n_state = (r_n == 16'd1) ? tri_pkg::S_MPREP : tri_pkg::S_POINT;
                    end else begin
                        n_state = (r_idx == r_n - 16'd1) ? tri_pkg::S_MPREP
                                                          : tri_pkg::S_POINT;
                    end
                end
            end
            tri_pkg::S_POINT: n_state = tri_pkg::S_EVAL;
            tri_pkg::S_MPREP: n_state = tri_pkg::S_MUL;
            tri_pkg::S_MUL:   n_state = (r_cnt == '0) ? tri_pkg::S_RND : tri_pkg::S_MUL;
            tri_pkg::S_RND:   n_state = tri_pkg::S_FIN;
            tri_pkg::S_FIN:   n_state = tri_pkg::S_IDLE;
            default:          n_state = tri_pkg::S_IDLE;
        endcase
    end

    always_comb begin
        busy         = (r_state != tri_pkg::S_IDLE);
        ev_req.start = (r_state == tri_pkg::S_EVAL);
        ev_req.op    = r_op;
        ev_req.x     = r_x;
        o_done       = r_done;
        o_rsp        = r_rsp;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= tri_pkg::S_IDLE;
            r_done  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_done  <= (accept && ((i_req.op == tri_pkg::OP_NONE) || (i_req.steps == '0)))
                       || (r_state == tri_pkg::S_FIN);
        end
    end

    always_ff @(posedge i_clk) begin
        case (r_state)
            tri_pkg::S_IDLE: begin
                r_op    <= i_req.op;
                r_a     <= i_req.lower_bound;
                r_b     <= i_req.upper_bound;
                r_n     <= i_req.steps;
                r_dneg  <= diff[IN_W];
                r_num   <= {(diff[IN_W] ? -diff : diff), tri_pkg::FRAC_BITS'(0)};
                r_rem   <= '0;
                r_quo   <= '0;
                r_cnt   <= CNT_W'(H_BITS - 1);
                r_sum   <= '0;
                r_sat   <= 1'b0;
                r_phase <= PH_A;
                r_rsp.integral <= '0;
                r_rsp.status   <= (i_req.op == tri_pkg::OP_NONE) ? tri_pkg::ST_BAD_OP
                                                                 : tri_pkg::ST_OK;
            end
            tri_pkg::S_DIV: begin
                if (!rem_sub[16]) begin
                    r_rem <= rem_sub[15:0];
                end else begin
                    r_rem <= rem_sh[15:0];
                end
                r_quo <= {r_quo[H_BITS-2:0], !rem_sub[16]};
                r_num <= {r_num[H_BITS-2:0], 1'b0};
                r_cnt <= r_cnt - 1'b1;
            end
            tri_pkg::S_SIGN: begin
                r_h <= r_dneg ? -$signed({1'b0, r_quo}) : $signed({1'b0, r_quo});
                r_x <= r_a;
            end
            tri_pkg::S_WAIT: begin
                if (ev_rsp.done) begin
                    if (sum_w[64] != sum_w[63]) begin
                        r_sum <= sum_w[64] ? {1'b1, 63'd0} : {1'b0, {63{1'b1}}};
                        r_sat <= 1'b1;
                    end else begin
                        r_sum <= sum_w[63:0];
                    end
                    if (r_phase == PH_A) begin
                        r_phase <= PH_B;
                        r_x     <= r_b;
                    end else if (r_phase == PH_B) begin
                        r_phase <= PH_MID;
                        r_idx   <= 16'd1;
                        r_acc   <= ACC_W'(r_h);
                    end else begin
                        r_idx <= r_idx + 16'd1;
                        r_acc <= r_acc + ACC_W'(r_h);
                    end
                end
            end
            tri_pkg::S_POINT: r_x <= pt_sum[IN_W-1:0];
            tri_pkg::S_MPREP: begin
                r_smag <= r_sum[63] ? 64'(-r_sum) : 64'(r_sum);
                r_neg  <= (r_dneg && (r_quo != '0)) != r_sum[63];
                r_phi  <= '0;
                r_cnt  <= CNT_W'(H_BITS - 1);
            end
            tri_pkg::S_MUL: begin
                // Shift-add over the bits of |h|, low bit first.
                r_phi <= mul_t[64:1];
                r_quo <= {mul_t[0], r_quo[H_BITS-1:1]};
                r_cnt <= r_cnt - 1'b1;
            end
            tri_pkg::S_RND: r_q <= rnd[105:2 * tri_pkg::FRAC_BITS + 1];
            tri_pkg::S_FIN: begin
                r_rsp.integral <= r_neg ? -$signed(q_sat[tri_pkg::OUT_W-1:0])
                                        : $signed(q_sat[tri_pkg::OUT_W-1:0]);
                r_rsp.status   <= (r_sat || (r_q > lim)) ? tri_pkg::ST_SAT : tri_pkg::ST_OK;
            end
            default: ;
        endcase
    end

    a_bad_op: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && (i_req.op == tri_pkg::OP_NONE)) |=>
            (o_done && (o_rsp.status == tri_pkg::ST_BAD_OP) && (o_rsp.integral == '0)))
        else $error("invalid select did not answer with error status");

    a_done_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> !busy)
        else $error("result beat while still busy");

    a_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> ((o_rsp.status == tri_pkg::ST_OK) || (o_rsp.status == tri_pkg::ST_BAD_OP)
                    || (o_rsp.status == tri_pkg::ST_SAT)))
        else $error("undefined status code");

    a_eval_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ev_req.start |=> (r_state == tri_pkg::S_WAIT) && !ev_rsp.done)
        else $error("evaluator answered too early");

endmodule
`default_nettype wire
